>>> sv/cdad_pkg.sv
// ----------------------------------------------------------------------------
// cdad_pkg: shared types and constants for the date adder
// Field widths, month codes, the month lengths and the structs that pass from the
// step unit to the sequencer and from the sequencer to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cdad_pkg;

  // Field widths
  localparam int unsigned DAY_BITS   = 5;
  localparam int unsigned MONTH_BITS = 4;
  localparam int unsigned YEAR_BITS  = 16;
  localparam int unsigned COUNT_BITS = 16;

  // Sum of day and count, wide enough for either operand plus a carry
  localparam int unsigned SUM_BITS =
    ((COUNT_BITS > DAY_BITS) ? COUNT_BITS : DAY_BITS) + 1;
  // Days skipped to reach the first of the next month (up to 32)
  localparam int unsigned SKIP_BITS = DAY_BITS + 1;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned IN_RAW_BITS  = DAY_BITS + MONTH_BITS + YEAR_BITS + COUNT_BITS;
  localparam int unsigned IN_DATA_W    = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_BITS = DAY_BITS + MONTH_BITS + YEAR_BITS;
  localparam int unsigned OUT_DATA_W   = ((OUT_RAW_BITS + 7) / 8) * 8;

  // Month codes
  localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
  localparam logic [MONTH_BITS-1:0] MONTH_APR = MONTH_BITS'(4);
  localparam logic [MONTH_BITS-1:0] MONTH_JUN = MONTH_BITS'(6);
  localparam logic [MONTH_BITS-1:0] MONTH_SEP = MONTH_BITS'(9);
  localparam logic [MONTH_BITS-1:0] MONTH_NOV = MONTH_BITS'(11);
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(12);

  // Month lengths
  localparam logic [DAY_BITS-1:0] LEN_LONG  = DAY_BITS'(31);
  localparam logic [DAY_BITS-1:0] LEN_SHORT = DAY_BITS'(30);
  localparam logic [DAY_BITS-1:0] LEN_FEB   = DAY_BITS'(28);
  localparam logic [DAY_BITS-1:0] LEN_LEAP  = DAY_BITS'(29);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } cdad_state_e;

  // Step unit result
  typedef struct packed {
    logic                  bad;
    logic                  fits;
    logic [DAY_BITS-1:0]   nxt_day;
    logic [MONTH_BITS-1:0] nxt_month;
    logic [YEAR_BITS-1:0]  nxt_year;
    logic [COUNT_BITS-1:0] nxt_count;
  } step_res_t;

  // Sequencer controls to the datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic advance;
    logic finish;
    logic out_load;
  } ctrl_t;

  // Length of a month, simple leap rule (year divisible by four)
  function automatic logic [DAY_BITS-1:0] month_len(
    input logic [MONTH_BITS-1:0] month,
    input logic [YEAR_BITS-1:0]  year
  );
    logic [DAY_BITS-1:0] len;
    len = LEN_LONG;
    if (month == MONTH_FEB) begin
      len = (year[1:0] == 2'b00) ? LEN_LEAP : LEN_FEB;
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      len = LEN_SHORT;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> sv/cdad_step.sv
// ----------------------------------------------------------------------------
// cdad_step: shared month step unit
// Checks the date, tests whether the remaining count ends inside the current
// month and otherwise advances to the first of the next month.
// ----------------------------------------------------------------------------
`default_nettype none

module cdad_step (
  input  logic [cdad_pkg::DAY_BITS-1:0]   day_i,
  input  logic [cdad_pkg::MONTH_BITS-1:0] month_i,
  input  logic [cdad_pkg::YEAR_BITS-1:0]  year_i,
  input  logic [cdad_pkg::COUNT_BITS-1:0] count_i,
  output cdad_pkg::step_res_t             res_o
);
  import cdad_pkg::*;

  logic [DAY_BITS-1:0]  len;
  logic [SUM_BITS-1:0]  sum;
  logic [SKIP_BITS-1:0] skip;

  // Length of the current month and the day reached by the whole count
  assign len  = month_len(month_i, year_i);
  assign sum  = SUM_BITS'(count_i) + SUM_BITS'(day_i);
  assign skip = SKIP_BITS'(len) - SKIP_BITS'(day_i) + SKIP_BITS'(1);

  // Flag an invalid start date and form the next step
  always_comb begin
    res_o.bad       = (month_i == '0) || (month_i > MONTH_DEC) || (day_i > len);
    res_o.fits      = (sum <= SUM_BITS'(len));
    res_o.nxt_day   = res_o.fits ? sum[DAY_BITS-1:0] : DAY_BITS'(1);
    res_o.nxt_count = count_i - COUNT_BITS'(skip);
    res_o.nxt_month = month_i + MONTH_BITS'(1);
    res_o.nxt_year  = year_i;
    if (month_i == MONTH_DEC) begin
      res_o.nxt_month = MONTH_JAN;
      res_o.nxt_year  = year_i + YEAR_BITS'(1);
    end
  end

endmodule

`default_nettype wire

>>> sv/cdad_fsm.sv
// ----------------------------------------------------------------------------
// cdad_fsm: sequencer for the date adder
// Takes a request, drives the step unit once a cycle until the count is used
// up or the date is found bad, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdad_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_free_i,
  input  cdad_pkg::step_res_t step_i,
  output cdad_pkg::ctrl_t     ctrl_o
);
  import cdad_pkg::*;

  cdad_state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (step_i.bad || step_i.fits) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controls
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.load     = in_valid_i;
      end
      ST_RUN: begin
        ctrl_o.finish  = step_i.bad || step_i.fits;
        ctrl_o.advance = !(step_i.bad || step_i.fits);
      end
      ST_DONE: begin
        ctrl_o.out_load = out_free_i;
      end
      default: ctrl_o = '0;
    endcase
  end

  // A bad or finished date leaves the step loop at once
  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish |=> state_q == ST_DONE)
    else $error("finish did not reach the done state");

  // At most one datapath action per cycle
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.load, ctrl_o.advance, ctrl_o.finish, ctrl_o.out_load}))
    else $error("more than one datapath action");

  // A request leads into the step loop
  a_load_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> state_q == ST_RUN)
    else $error("load did not start the step loop");

endmodule

`default_nettype wire

>>> sv/calendar_date_add_days.sv
// Stepping: the month step unit advances one month per cycle, so the time from the
// accepted request to a valid result grows with the months crossed by the count.
// Throughput: one request at a time; the next request is taken once the
// result sits in the output register, even while that result waits.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// calendar_date_add_days: adds a day count to a calendar date
// Holds the working date, steps it month by month through the shared step
// unit and presents the end date with a bad date flag on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_add_days (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request: start_day, start_month, start_year, day_count (from bit 0 up)
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cdad_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Result: end_day, end_month, end_year (from bit 0 up)
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [cdad_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // Result flag: bad_date
  output logic                             m_axis_tuser
);
  import cdad_pkg::*;

  localparam int unsigned MONTH_LSB = DAY_BITS;
  localparam int unsigned YEAR_LSB  = MONTH_LSB + MONTH_BITS;
  localparam int unsigned COUNT_LSB = YEAR_LSB + YEAR_BITS;

  logic [DAY_BITS-1:0]   day_q,   day_d;
  logic [MONTH_BITS-1:0] month_q, month_d;
  logic [YEAR_BITS-1:0]  year_q,  year_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  bad_q,   bad_d;

  logic [DAY_BITS-1:0]   out_day_q;
  logic [MONTH_BITS-1:0] out_month_q;
  logic [YEAR_BITS-1:0]  out_year_q;
  logic                  out_bad_q;
  logic                  out_valid_q, out_valid_d;

  step_res_t step;
  ctrl_t     ctrl;
  logic      out_free;

  // Shared month step unit
  cdad_step u_step (
    .day_i   (day_q),
    .month_i (month_q),
    .year_i  (year_q),
    .count_i (count_q),
    .res_o   (step)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer
  cdad_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .step_i     (step),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;

  // Load a request, advance a month, or settle the final day and the bad flag
  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    count_d = count_q;
    bad_d   = bad_q;
    priority if (ctrl.load) begin
      day_d   = s_axis_tdata[MONTH_LSB-1:0];
      month_d = s_axis_tdata[YEAR_LSB-1:MONTH_LSB];
      year_d  = s_axis_tdata[COUNT_LSB-1:YEAR_LSB];
      count_d = s_axis_tdata[COUNT_LSB+COUNT_BITS-1:COUNT_LSB];
    end else if (ctrl.advance) begin
      day_d   = step.nxt_day;
      month_d = step.nxt_month;
      year_d  = step.nxt_year;
      count_d = step.nxt_count;
    end else if (ctrl.finish) begin
      bad_d = step.bad;
      if (!step.bad) day_d = step.nxt_day;
    end
  end

  // Working date registers
  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    count_q <= count_d;
    bad_q   <= bad_d;
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_day_q   <= day_q;
      out_month_q <= month_q;
      out_year_q  <= year_q;
      out_bad_q   <= bad_q;
    end
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_year_q, out_month_q, out_day_q});
  assign m_axis_tuser  = out_bad_q;

  // A taken request blocks further requests while it is worked on
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A good result always carries a month in range
  a_good_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid) && !m_axis_tuser) |->
      (out_month_q >= MONTH_JAN && out_month_q <= MONTH_DEC))
    else $error("good result with month out of range");

  // The step loop never leaves an invalid working date behind
  a_step_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.advance |=> !step.bad)
    else $error("month step produced an invalid date");

endmodule

`default_nettype wire
